[src/lstp_pkg.sv]
package lstp_pkg;

  // Fixed field widths of the words on the ports.
  localparam int COORD_BITS   = 16;
  localparam int POS_BITS_DEF = 32;
  localparam int SPU_BITS     = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [SPU_BITS-1:0] SPU_RESET = 8'd50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPU_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPU_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPU_Z = 2'd2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] target_z;
  } in_word_t;

  typedef struct packed {
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic move_done;
    logic busy_res;
    logic load_rejected;
  } out_word_t;

  // Steps-per-unit settings handed from the register file to the engine.
  typedef struct packed {
    logic [SPU_BITS-1:0] spu_x;
    logic [SPU_BITS-1:0] spu_y;
    logic [SPU_BITS-1:0] spu_z;
  } spu_cfg_t;

endpackage

[src/lstp_cfg_regs.sv]
module lstp_cfg_regs import lstp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SPU_BITS-1:0]     cfg_data_i,
  output spu_cfg_t                cfg_o
);

  spu_cfg_t cfg_q, cfg_d;

  // Decode the write; an index beyond the register list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPU_X: cfg_d.spu_x = cfg_data_i;
        CFG_SPU_Y: cfg_d.spu_y = cfg_data_i;
        CFG_SPU_Z: cfg_d.spu_z = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spu_x <= SPU_RESET;
      cfg_q.spu_y <= SPU_RESET;
      cfg_q.spu_z <= SPU_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/lstp_engine.sv]
module lstp_engine import lstp_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  spu_cfg_t  cfg_i,
  output out_word_t res_o
);

  // Positions only ever hold wrapped targets, so the narrower width is enough.
  localparam int EFF = (COORD_BITS < POS_BITS) ? COORD_BITS : POS_BITS;
  localparam int MB  = EFF + 1;
  localparam int PB  = MB + SPU_BITS;
  localparam int DB  = EFF + SPU_BITS;
  localparam int EB  = DB + 3;

  logic signed [EFF-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [EFF-1:0] pos_x_d, pos_y_d, pos_z_d;
  logic [DB-1:0]         dist_x_q, dist_y_q, dist_z_q;
  logic [DB-1:0]         dist_x_d, dist_y_d, dist_z_d;
  logic signed [EB-1:0]  err_f_q, err_s_q, err_f_d, err_s_d;
  logic [DB-1:0]         left_q, left_d;
  axis_e                 drv_q, drv_d;
  logic [2:0]            dirs_q, dirs_d;
  logic                  active_q, active_d;

  logic signed [EFF-1:0] tgt_x, tgt_y, tgt_z;
  logic signed [MB-1:0]  dlt_x, dlt_y, dlt_z;
  logic [MB-1:0]         mag_x, mag_y, mag_z;
  logic [PB-1:0]         prod_x, prod_y, prod_z;
  logic [DB-1:0]         new_x, new_y, new_z;
  logic [2:0]            new_dirs;
  axis_e                 new_drv;
  logic [DB-1:0]         ld_m, ld_f, ld_s;
  logic [DB-1:0]         tk_m, tk_f, tk_s;
  logic                  hit_f, hit_s;
  logic [2:0]            tk_steps;

  // Load path: wrap the target, take the distance and scale it.
  assign tgt_x = word_i.target_x[EFF-1:0];
  assign tgt_y = word_i.target_y[EFF-1:0];
  assign tgt_z = word_i.target_z[EFF-1:0];

  assign dlt_x = $signed({tgt_x[EFF-1], tgt_x}) - $signed({pos_x_q[EFF-1], pos_x_q});
  assign dlt_y = $signed({tgt_y[EFF-1], tgt_y}) - $signed({pos_y_q[EFF-1], pos_y_q});
  assign dlt_z = $signed({tgt_z[EFF-1], tgt_z}) - $signed({pos_z_q[EFF-1], pos_z_q});

  assign mag_x = dlt_x[MB-1] ? MB'(-dlt_x) : MB'(dlt_x);
  assign mag_y = dlt_y[MB-1] ? MB'(-dlt_y) : MB'(dlt_y);
  assign mag_z = dlt_z[MB-1] ? MB'(-dlt_z) : MB'(dlt_z);

  assign new_dirs = {!dlt_z[MB-1] && (dlt_z != '0),
                     !dlt_y[MB-1] && (dlt_y != '0),
                     !dlt_x[MB-1] && (dlt_x != '0)};

  assign prod_x = PB'(mag_x) * PB'(cfg_i.spu_x);
  assign prod_y = PB'(mag_y) * PB'(cfg_i.spu_y);
  assign prod_z = PB'(mag_z) * PB'(cfg_i.spu_z);
  assign new_x  = prod_x[DB-1:0];
  assign new_y  = prod_y[DB-1:0];
  assign new_z  = prod_z[DB-1:0];

  // Driving axis: largest distance, ties go to x, then y.
  always_comb begin
    if (new_x >= new_y && new_x >= new_z) begin
      new_drv = AXIS_X;
    end else if (new_y >= new_z) begin
      new_drv = AXIS_Y;
    end else begin
      new_drv = AXIS_Z;
    end
  end

  always_comb begin
    case (new_drv)
      AXIS_Y: begin
        ld_m = new_y; ld_f = new_x; ld_s = new_z;
      end
      AXIS_Z: begin
        ld_m = new_z; ld_f = new_y; ld_s = new_x;
      end
      default: begin
        ld_m = new_x; ld_f = new_y; ld_s = new_z;
      end
    endcase
  end

  // Tick path: pick the stored distances for the current pairing.
  always_comb begin
    case (drv_q)
      AXIS_Y: begin
        tk_m = dist_y_q; tk_f = dist_x_q; tk_s = dist_z_q;
      end
      AXIS_Z: begin
        tk_m = dist_z_q; tk_f = dist_y_q; tk_s = dist_x_q;
      end
      default: begin
        tk_m = dist_x_q; tk_f = dist_y_q; tk_s = dist_z_q;
      end
    endcase
  end

  assign hit_f = !err_f_q[EB-1];
  assign hit_s = !err_s_q[EB-1];

  // Step bits in x, y, z order for the current driving axis.
  always_comb begin
    case (drv_q)
      AXIS_Y:  tk_steps = {hit_s, 1'b1, hit_f};
      AXIS_Z:  tk_steps = {1'b1, hit_f, hit_s};
      default: tk_steps = {hit_s, hit_f, 1'b1};
    endcase
  end

  // Next state and the result word.
  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    pos_z_d  = pos_z_q;
    dist_x_d = dist_x_q;
    dist_y_d = dist_y_q;
    dist_z_d = dist_z_q;
    err_f_d  = err_f_q;
    err_s_d  = err_s_q;
    left_d   = left_q;
    drv_d    = drv_q;
    dirs_d   = dirs_q;
    active_d = active_q;
    res_o    = '0;

    if (word_i.cmd == CMD_LOAD) begin
      if (active_q) begin
        res_o.load_rejected = 1'b1;
      end else begin
        pos_x_d  = tgt_x;
        pos_y_d  = tgt_y;
        pos_z_d  = tgt_z;
        dist_x_d = new_x;
        dist_y_d = new_y;
        dist_z_d = new_z;
        drv_d    = new_drv;
        dirs_d   = new_dirs;
        err_f_d  = $signed({2'b00, ld_f, 1'b0}) - $signed({3'b000, ld_m});
        err_s_d  = $signed({2'b00, ld_s, 1'b0}) - $signed({3'b000, ld_m});
        left_d   = ld_m;
        active_d = (ld_m != '0);
        res_o.move_done = (ld_m == '0);
      end
    end else if (active_q) begin
      err_f_d = err_f_q - (hit_f ? $signed({2'b00, tk_m, 1'b0}) : $signed(EB'(0)))
              + $signed({2'b00, tk_f, 1'b0});
      err_s_d = err_s_q - (hit_s ? $signed({2'b00, tk_m, 1'b0}) : $signed(EB'(0)))
              + $signed({2'b00, tk_s, 1'b0});
      left_d  = left_q - DB'(1);
      {res_o.step_z, res_o.step_y, res_o.step_x} = tk_steps;
      if (left_q == DB'(1)) begin
        active_d        = 1'b0;
        res_o.move_done = 1'b1;
      end
    end else begin
      res_o.move_done = 1'b1;
    end

    {res_o.dir_z, res_o.dir_y, res_o.dir_x} = dirs_d;
    res_o.busy_res = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      dist_x_q <= '0;
      dist_y_q <= '0;
      dist_z_q <= '0;
      err_f_q  <= '0;
      err_s_q  <= '0;
      left_q   <= '0;
      drv_q    <= AXIS_X;
      dirs_q   <= '0;
      active_q <= 1'b0;
    end else if (fire_i) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pos_z_q  <= pos_z_d;
      dist_x_q <= dist_x_d;
      dist_y_q <= dist_y_d;
      dist_z_q <= dist_z_d;
      err_f_q  <= err_f_d;
      err_s_q  <= err_s_d;
      left_q   <= left_d;
      drv_q    <= drv_d;
      dirs_q   <= dirs_d;
      active_q <= active_d;
    end
  end

  // A running move always has ticks left.
  a_active_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("active move with no ticks left");

  // The tick that uses up the last step ends the move.
  a_last_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && word_i.cmd == CMD_TICK && active_q && left_q == DB'(1)) |=> !active_q)
    else $error("move did not end on its last tick");

  // A rejected load leaves the position alone.
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && word_i.cmd == CMD_LOAD && active_q) |=>
      ($stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q)))
    else $error("rejected load moved the position");

  // During a move the driving axis has the largest distance.
  a_drv_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (tk_m >= tk_f && tk_m >= tk_s))
    else $error("driving axis is not the longest");

endmodule

[src/three_axis_line_stepper.sv]
// Channel   Direction  Word         Handshake
// in        input      in_word_t    in_valid_i / in_stall_o
// out       output     out_word_t   out_valid_o / out_stall_i
// cfg       input      spu x, y, z  cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each word passes through the input register, then through the engine into the
// output register. One word a cycle is taken while the output side keeps up;
// the load path's three scaling multiplies and the tick's error update set the
// cycle time.
// Reset clears the move state, sets the steps-per-unit registers to 50 and
// empties both registers. A stalled output holds its word; the input register
// still takes one more word before in_stall_o rises.
module three_axis_line_stepper import lstp_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SPU_BITS-1:0]     cfg_data_i
);

  in_word_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_word_t out_q, res;
  logic      out_valid_q, out_valid_d;
  logic      advance, fire, accept;
  spu_cfg_t  cfg;

  lstp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lstp_engine #(
    .POS_BITS (POS_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Pipeline flow: the output register frees up when empty or taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A word held in the input register is not lost while the output stalls.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("input word dropped during stall");

  // Each engine pass lands in the output register.
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("engine result not registered");

endmodule
